// File: rtl/lvs3_pkg.sv
// Shared types, widths and axis helpers for the 3D line voxel stepper.
package lvs3_pkg;

  localparam int COORD_W = 16;
  localparam int TD_W    = COORD_W + 1;  // doubled magnitude of an axis delta
  localparam int ERR_W   = COORD_W + 4;  // signed minor error term
  localparam int NUM_AX  = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [TD_W-1:0]           tdelta_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic               req_type;
    logic [2:0][COORD_W-1:0] start_pos;
    logic [2:0][COORD_W-1:0] end_pos;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } stage_t;

  // Minor axes in ascending order: sel 0 gives the lower one.
  function automatic axis_t minor_axis(axis_t maj, logic sel);
    axis_t ax;
    unique case (maj)
      AXIS_X:  ax = sel ? AXIS_Z : AXIS_Y;
      AXIS_Y:  ax = sel ? AXIS_Z : AXIS_X;
      default: ax = sel ? AXIS_Y : AXIS_X;
    endcase
    return ax;
  endfunction

  // Step by +1 when sign is 0, by -1 when sign is 1.
  function automatic coord_t step_coord(coord_t pos, logic sgn);
    return coord_t'(pos + coord_t'({{(COORD_W-1){sgn}}, 1'b1}));
  endfunction

endpackage

// File: rtl/lvs3_in_if.sv
// Request channel: valid/ready handshake carrying one line request.
interface lvs3_in_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  lvs3_pkg::coord_t       start_x;
  lvs3_pkg::coord_t       start_y;
  lvs3_pkg::coord_t       start_z;
  lvs3_pkg::coord_t       end_x;
  lvs3_pkg::coord_t       end_y;
  lvs3_pkg::coord_t       end_z;

  modport source (output valid, req_type, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, req_type, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

// File: rtl/lvs3_out_if.sv
// Point channel: valid/ready handshake carrying one emitted line point.
interface lvs3_out_if;
  logic             valid;
  logic             ready;
  lvs3_pkg::coord_t point_x;
  lvs3_pkg::coord_t point_y;
  lvs3_pkg::coord_t point_z;
  logic             last_point;
  logic             no_line;

  modport source (output valid, point_x, point_y, point_z, last_point, no_line,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, no_line,
                  output ready);
endinterface

// File: rtl/lvs3_in_stage.sv
// Input register stage: captures one request per transfer.
module lvs3_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  lvs3_in_if.sink            in_ch,
  input  logic               core_ready,
  output lvs3_pkg::stage_t   stage
);

  logic           valid_r, valid_nxt;
  lvs3_pkg::req_t req_r, req_nxt;
  logic           in_fire;

  assign in_ch.ready = !valid_r || core_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    req_nxt   = req_r;
    if (in_fire) begin
      valid_nxt         = 1'b1;
      req_nxt.req_type  = in_ch.req_type;
      req_nxt.start_pos = {in_ch.start_z, in_ch.start_y, in_ch.start_x};
      req_nxt.end_pos   = {in_ch.end_z, in_ch.end_y, in_ch.end_x};
    end else if (core_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  assign stage.valid = valid_r;
  assign stage.req   = req_r;

endmodule

// File: rtl/lvs3_core.sv
// Line state, one-pass setup/step logic and the result register.
module lvs3_core (
  input  logic               clk,
  input  logic               rst_n,
  input  lvs3_pkg::stage_t   stage,
  output logic               core_ready,
  lvs3_out_if.source         out_ch
);

  localparam int CW = lvs3_pkg::COORD_W;
  localparam int EW = lvs3_pkg::ERR_W;

  // line state
  lvs3_pkg::coord_t  cur_r   [3];
  lvs3_pkg::coord_t  cur_nxt [3];
  lvs3_pkg::coord_t  end_r   [3];
  lvs3_pkg::coord_t  end_nxt [3];
  lvs3_pkg::tdelta_t td_r    [3];
  lvs3_pkg::tdelta_t td_nxt  [3];
  logic [2:0]        sgn_r, sgn_nxt;
  lvs3_pkg::err_t    err_r   [2];
  lvs3_pkg::err_t    err_nxt [2];
  lvs3_pkg::axis_t   major_r, major_nxt;
  logic              active_r, active_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  lvs3_pkg::coord_t  pt_r [3];
  logic              last_r, last_nxt;
  logic              nl_r, nl_nxt;

  // setup terms
  logic signed [CW:0] delta [3];
  logic [CW:0]        mag   [3];
  logic [CW-1:0]      absd  [3];
  lvs3_pkg::axis_t    setup_maj;
  lvs3_pkg::axis_t    mins  [2];
  lvs3_pkg::axis_t    cur_min;
  logic               load;

  function automatic lvs3_pkg::err_t err_t_sub(lvs3_pkg::err_t e, lvs3_pkg::tdelta_t t);
    return lvs3_pkg::err_t'(e - $signed(EW'(t)));
  endfunction

  assign load       = stage.valid && (!out_valid_r || out_ch.ready);
  assign core_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      delta[i] = $signed({stage.req.end_pos[i][CW-1], stage.req.end_pos[i]})
               - $signed({stage.req.start_pos[i][CW-1], stage.req.start_pos[i]});
      mag[i]   = delta[i][CW] ? (CW+1)'(-delta[i]) : delta[i];
      absd[i]  = mag[i][CW-1:0];
    end
    // ties go to x, then y
    if (absd[0] >= absd[1] && absd[0] >= absd[2]) begin
      setup_maj = lvs3_pkg::AXIS_X;
    end else if (absd[1] >= absd[2]) begin
      setup_maj = lvs3_pkg::AXIS_Y;
    end else begin
      setup_maj = lvs3_pkg::AXIS_Z;
    end
  end

  always_comb begin
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    td_nxt        = td_r;
    sgn_nxt       = sgn_r;
    err_nxt       = err_r;
    major_nxt     = major_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    last_nxt      = last_r;
    nl_nxt        = nl_r;
    cur_min       = lvs3_pkg::AXIS_X;
    mins[0]       = lvs3_pkg::minor_axis(setup_maj, 1'b0);
    mins[1]       = lvs3_pkg::minor_axis(setup_maj, 1'b1);

    if (load) begin
      out_valid_nxt = 1'b1;
      nl_nxt        = 1'b0;
      if (stage.req.req_type == lvs3_pkg::REQ_START) begin
        for (int i = 0; i < 3; i++) begin
          cur_nxt[i] = stage.req.start_pos[i];
          end_nxt[i] = stage.req.end_pos[i];
          td_nxt[i]  = {absd[i], 1'b0};
          sgn_nxt[i] = delta[i][CW] || (delta[i] == '0);
        end
        for (int k = 0; k < 2; k++) begin
          err_nxt[k] = $signed(EW'({absd[mins[k]], 1'b0}))
                     - $signed(EW'(absd[setup_maj]));
        end
        major_nxt  = setup_maj;
        last_nxt   = (absd[setup_maj] == '0);
        active_nxt = (absd[setup_maj] != '0);
      end else if (!active_r) begin
        // no line: repeat the last point
        last_nxt = 1'b0;
        nl_nxt   = 1'b1;
      end else begin
        for (int k = 0; k < 2; k++) begin
          cur_min    = lvs3_pkg::minor_axis(major_r, k[0]);
          err_nxt[k] = err_r[k];
          if (!err_r[k][EW-1]) begin
            cur_nxt[cur_min] = lvs3_pkg::step_coord(cur_r[cur_min], sgn_r[cur_min]);
            err_nxt[k]       = err_t_sub(err_r[k], td_r[major_r]);
          end
          err_nxt[k] = lvs3_pkg::err_t'(err_nxt[k] + $signed(EW'(td_r[cur_min])));
        end
        cur_nxt[major_r] = lvs3_pkg::step_coord(cur_r[major_r], sgn_r[major_r]);
        last_nxt         = (lvs3_pkg::step_coord(cur_r[major_r], sgn_r[major_r])
                            == end_r[major_r]);
        active_nxt       = !last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cur_r[i] <= '0;
        end_r[i] <= '0;
        td_r[i]  <= '0;
      end
      err_r[0]    <= '0;
      err_r[1]    <= '0;
      sgn_r       <= '0;
      major_r     <= lvs3_pkg::AXIS_X;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      end_r       <= end_nxt;
      td_r        <= td_nxt;
      err_r       <= err_nxt;
      sgn_r       <= sgn_nxt;
      major_r     <= major_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      pt_r <= cur_nxt;
    end
    last_r <= last_nxt;
    nl_r   <= nl_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.point_x    = pt_r[0];
  assign out_ch.point_y    = pt_r[1];
  assign out_ch.point_z    = pt_r[2];
  assign out_ch.last_point = last_r;
  assign out_ch.no_line    = nl_r;

  a_nl_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(nl_r && last_r))
    else $error("no_line and last_point both set");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_nxt) |=> !active_r)
    else $error("line still active after its last point");

  a_active_major_moves: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (td_r[major_r] != '0))
    else $error("active line with zero major delta");

  a_active_not_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cur_r[major_r] != end_r[major_r]))
    else $error("active line already at its end point");

endmodule

// File: rtl/line_voxel_stepper_3d.sv
// A request goes through the request register, then the point register, to out_ch.
// Throughput: one request per cycle while out_ch is ready; setup and each step
//   are one add/compare/select pass between the request and point registers.
// Backpressure on out_ch stalls the request register; one request still enters
//   while a finished point waits.
// Reset (rst_n low, synchronous): no line active, current point and state zero.
module line_voxel_stepper_3d (
  input  logic        clk,
  input  logic        rst_n,
  lvs3_in_if.sink     in_ch,
  lvs3_out_if.source  out_ch
);

  lvs3_pkg::stage_t stage;
  logic             core_ready;

  lvs3_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .core_ready (core_ready),
    .stage      (stage)
  );

  lvs3_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .core_ready (core_ready),
    .out_ch     (out_ch)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_voxel_stepper_3d: directed and random line traces.
module tb;

  localparam int STALL_LIMIT = 1000;
  localparam int RAND_ITEMS  = 600;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    lvs3_pkg::req_kind_t kind;
    lvs3_pkg::coord_t    from_x, from_y, from_z;
    lvs3_pkg::coord_t    to_x, to_y, to_z;
  } line_req_t;

  typedef struct {
    lvs3_pkg::coord_t x, y, z;
    logic             last, no_line;
  } voxel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lvs3_in_if  in_ch ();
  lvs3_out_if out_ch ();

  line_voxel_stepper_3d dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  line_req_t line_reqs [$];
  voxel_t    voxels_due [$];

  // Tracer state
  int              pos_now [3];
  int              pos_end [3];
  int              span2 [3];
  logic            step_neg [3];
  int              err_minor [2];
  lvs3_pkg::axis_t dom_axis;
  logic            tracing;

  logic req_moved;
  int   idle_cycles;
  int   fed_count = 0;
  int   errors = 0;
  int   n_starts = 0, n_advances = 0, n_points = 0, n_last = 0, n_noline = 0;

  task automatic trace_step(input line_req_t r, output voxel_t v);
    int              i;
    int              d;
    lvs3_pkg::axis_t mn [2];
    v.last    = 1'b0;
    v.no_line = 1'b0;
    if (r.kind == lvs3_pkg::REQ_START) begin
      pos_now[0] = r.from_x;
      pos_now[1] = r.from_y;
      pos_now[2] = r.from_z;
      pos_end[0] = r.to_x;
      pos_end[1] = r.to_y;
      pos_end[2] = r.to_z;
      for (i = 0; i < 3; i++) begin
        d           = pos_end[i] - pos_now[i];
        span2[i]    = 2 * (d < 0 ? -d : d);
        step_neg[i] = (d <= 0);
      end
      // Ties favor x, then y
      if (span2[0] >= span2[1] && span2[0] >= span2[2]) dom_axis = lvs3_pkg::AXIS_X;
      else if (span2[1] >= span2[2])                     dom_axis = lvs3_pkg::AXIS_Y;
      else                                               dom_axis = lvs3_pkg::AXIS_Z;
    end
    case (dom_axis)
      lvs3_pkg::AXIS_X: begin
        mn[0] = lvs3_pkg::AXIS_Y;
        mn[1] = lvs3_pkg::AXIS_Z;
      end
      lvs3_pkg::AXIS_Y: begin
        mn[0] = lvs3_pkg::AXIS_X;
        mn[1] = lvs3_pkg::AXIS_Z;
      end
      default: begin
        mn[0] = lvs3_pkg::AXIS_X;
        mn[1] = lvs3_pkg::AXIS_Y;
      end
    endcase
    if (r.kind == lvs3_pkg::REQ_START) begin
      for (i = 0; i < 2; i++) err_minor[i] = span2[mn[i]] - span2[dom_axis] / 2;
      v.last  = (pos_now[dom_axis] == pos_end[dom_axis]);
      tracing = !v.last;
    end else if (!tracing) begin
      v.no_line = 1'b1;
    end else begin
      // Minor steps first, then the dominant axis
      for (i = 0; i < 2; i++) begin
        if (err_minor[i] >= 0) begin
          pos_now[mn[i]] += step_neg[mn[i]] ? -1 : 1;
          err_minor[i]   -= span2[dom_axis];
        end
        err_minor[i] += span2[mn[i]];
      end
      pos_now[dom_axis] += step_neg[dom_axis] ? -1 : 1;
      v.last = (pos_now[dom_axis] == pos_end[dom_axis]);
      if (v.last) tracing = 1'b0;
    end
    v.x = lvs3_pkg::coord_t'(pos_now[0]);
    v.y = lvs3_pkg::coord_t'(pos_now[1]);
    v.z = lvs3_pkg::coord_t'(pos_now[2]);
  endtask

  task automatic add_start(input int sx, sy, sz, ex, ey, ez);
    line_req_t r;
    r.kind   = lvs3_pkg::REQ_START;
    r.from_x = lvs3_pkg::coord_t'(sx);
    r.from_y = lvs3_pkg::coord_t'(sy);
    r.from_z = lvs3_pkg::coord_t'(sz);
    r.to_x   = lvs3_pkg::coord_t'(ex);
    r.to_y   = lvs3_pkg::coord_t'(ey);
    r.to_z   = lvs3_pkg::coord_t'(ez);
    line_reqs = {line_reqs, r};
  endtask

  // Endpoint fields are don't-care on advances; fill them with noise
  task automatic add_advance(input int n);
    line_req_t r;
    repeat (n) begin
      r.kind   = lvs3_pkg::REQ_ADVANCE;
      r.from_x = lvs3_pkg::coord_t'($urandom);
      r.from_y = lvs3_pkg::coord_t'($urandom);
      r.from_z = lvs3_pkg::coord_t'($urandom);
      r.to_x   = lvs3_pkg::coord_t'($urandom);
      r.to_y   = lvs3_pkg::coord_t'($urandom);
      r.to_z   = lvs3_pkg::coord_t'($urandom);
      line_reqs = {line_reqs, r};
    end
  endtask

  // Keep the end inside the coordinate range by flipping the offset
  function automatic int end_near(input int base, input int d);
    int e;
    e = base + d;
    if (e > 32767 || e < -32768) e = base - d;
    return e;
  endfunction

  function automatic int abs_int(input int a);
    return (a < 0) ? -a : a;
  endfunction

  // Monitor: prediction on request transfers, checking on point transfers
  always @(posedge clk) begin
    line_req_t r;
    voxel_t    exp_pt;
    voxel_t    got;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_now[i]  = 0;
        pos_end[i]  = 0;
        span2[i]    = 0;
        step_neg[i] = 1'b0;
      end
      err_minor[0] = 0;
      err_minor[1] = 0;
      dom_axis     = lvs3_pkg::AXIS_X;
      tracing      = 1'b0;
      req_moved   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_moved <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        r.kind   = lvs3_pkg::req_kind_t'(in_ch.req_type);
        r.from_x = in_ch.start_x;
        r.from_y = in_ch.start_y;
        r.from_z = in_ch.start_z;
        r.to_x   = in_ch.end_x;
        r.to_y   = in_ch.end_y;
        r.to_z   = in_ch.end_z;
        trace_step(r, exp_pt);
        voxels_due = {voxels_due, exp_pt};
        if (r.kind == lvs3_pkg::REQ_START) n_starts++;
        else                               n_advances++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.x       = out_ch.point_x;
        got.y       = out_ch.point_y;
        got.z       = out_ch.point_z;
        got.last    = out_ch.last_point;
        got.no_line = out_ch.no_line;
        n_points++;
        if (got.last === 1'b1)    n_last++;
        if (got.no_line === 1'b1) n_noline++;
        if (voxels_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: point (%0d,%0d,%0d) with no request pending", $realtime,
                     got.x, got.y, got.z);
        end else begin
          exp_pt = voxels_due.pop_front();
          if (got.x !== exp_pt.x || got.y !== exp_pt.y || got.z !== exp_pt.z ||
              got.last !== exp_pt.last || got.no_line !== exp_pt.no_line) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: point mismatch: expected (%0d,%0d,%0d) last=%b no_line=%b,",
                        " got (%0d,%0d,%0d) last=%b no_line=%b"},
                       $realtime, exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.last, exp_pt.no_line,
                       got.x, got.y, got.z, got.last, got.no_line);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Driver: hold a request until its transfer, gaps and stalls at random
  always @(negedge clk) begin
    line_req_t nx;
    bit        calm;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.req_type <= lvs3_pkg::REQ_START;
      in_ch.start_x  <= '0;
      in_ch.start_y  <= '0;
      in_ch.start_z  <= '0;
      in_ch.end_x    <= '0;
      in_ch.end_y    <= '0;
      in_ch.end_z    <= '0;
      out_ch.ready   <= 1'b0;
    end else begin
      calm = (fed_count >= 200 && fed_count < 320);
      out_ch.ready <= calm || ($urandom_range(99) >= 25);
      if (!in_ch.valid || req_moved) begin
        if (line_reqs.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
          nx = line_reqs.pop_front();
          in_ch.req_type <= nx.kind;
          in_ch.start_x  <= nx.from_x;
          in_ch.start_y  <= nx.from_y;
          in_ch.start_z  <= nx.from_z;
          in_ch.end_x    <= nx.to_x;
          in_ch.end_y    <= nx.to_y;
          in_ch.end_z    <= nx.to_z;
          in_ch.valid    <= 1'b1;
          fed_count++;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int dir_n;
    int pick, reach, len, steps;
    int bx, by, bz, ex, ey, ez;

    // Advance straight out of reset: no line
    add_advance(1);
    // Full-range diagonal, three-way tie goes to x
    add_start(-32768, -32768, -32768, 32767, 32767, 32767);
    add_advance(1);
    // Same, all axes stepping down
    add_start(32767, 32767, 32767, -32768, -32768, -32768);
    add_advance(1);
    // y and z tie: y dominant, run past the end
    add_start(0, 0, 0, 1, 3, -3);
    add_advance(4);
    // z dominant, negative z and y
    add_start(5, -5, 100, 7, -6, 96);
    add_advance(5);
    // Single-point line
    add_start(10, 20, 30, 10, 20, 30);
    add_advance(1);
    // Restart while a line is running
    add_start(0, 0, 0, 8, 2, 1);
    add_advance(2);
    add_start(-3, -3, -3, -2, 0, -3);
    add_advance(4);
    dir_n = line_reqs.size();

    while (line_reqs.size() < dir_n + RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        // Well-formed line, mostly short, usually traced to or just past its end, else up to 8 steps
        reach = ($urandom_range(9) == 0) ? 300 : 12;
        bx = int'($urandom_range(65535)) - 32768;
        by = int'($urandom_range(65535)) - 32768;
        bz = int'($urandom_range(65535)) - 32768;
        ex = end_near(bx, int'($urandom_range(2 * reach)) - reach);
        ey = end_near(by, int'($urandom_range(2 * reach)) - reach);
        ez = end_near(bz, int'($urandom_range(2 * reach)) - reach);
        add_start(bx, by, bz, ex, ey, ez);
        len = abs_int(ex - bx);
        if (abs_int(ey - by) > len) len = abs_int(ey - by);
        if (abs_int(ez - bz) > len) len = abs_int(ez - bz);
        if (len <= 30 && $urandom_range(4) != 0)
          steps = len + $urandom_range(2);
        else
          steps = $urandom_range((len < 8) ? len : 8);
        add_advance(steps);
      end else if (pick < 90) begin
        add_advance($urandom_range(1, 3));
      end else begin
        add_start(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                  int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                  int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768);
        add_advance($urandom_range(2));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (line_reqs.size() != 0 || in_ch.valid) @(posedge clk);
    while (voxels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Traced %0d line starts and %0d advance requests, %0d points compared",
             n_starts, n_advances, n_points);
    $display("Points seen: %0d line ends, %0d advances with no line, %0d mismatches",
             n_last, n_noline, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
